[hw/rtl/srpd_pkg.sv]
// ----------------------------------------------------------------------------
// srpd_pkg
// Shared constants for the sprite decoder: command and result codes, field
// widths and the fixed values of the sprite file format.
// ----------------------------------------------------------------------------
package srpd_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 96;
   localparam int SPRITE_W    = 17;
   localparam int COLOR_W     = 24;

   localparam logic [1:0] CMD_PALETTE = 2'd0;
   localparam logic [1:0] CMD_BEGIN   = 2'd1;
   localparam logic [1:0] CMD_BYTE    = 2'd2;
   localparam logic [1:0] CMD_END     = 2'd3;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;

   localparam logic [7:0]  MAGIC_S         = 8'h53;
   localparam logic [7:0]  MAGIC_P         = 8'h50;
   localparam logic [15:0] MIN_TC_VERSION  = 16'h0201;
   localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;

endpackage

[hw/rtl/srpd_ram.sv]
// ----------------------------------------------------------------------------
// srpd_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module srpd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/sprite_rle_palette_decoder.sv]
// ----------------------------------------------------------------------------
// sprite_rle_palette_decoder
// Parses a sprite file byte stream, skips to the selected image and emits its
// header and its pixel runs, with indexed pixels looked up in a palette RAM.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Contents
//  req_    | in        | req_tvalid/tready   | tuser command, tdata bytes
//  rsp_    | out       | rsp_tvalid/tready   | tuser kind, tlast, tdata fields
//  csr_    | in        | csr_valid/ready     | csr_data wanted sprite index
//
// One request transaction is taken per cycle while req_tready is high; any result it
// yields passes the palette RAM read and the output register before it reaches rsp_.
// The palette RAM has one write and one read port.
// Reset clears the parser phase and the pipeline valid flags; palette
// contents are undefined until written.
// While rsp_ is stalled, requests are still taken until one more result waits
// behind it; then req_tready drops.
module sprite_rle_palette_decoder #(
   parameter int PALETTE_ENTRIES = srpd_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command
   input  logic [1:0]                      req_tuser,
   // data_byte, palette_index, entry_blue, entry_green, entry_red
   input  logic [srpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   // width, height, red, green, blue, alpha, run_length
   output logic [srpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srpd_pkg::SPRITE_W-1:0]   csr_data
);

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HEAD = 3'd1;
   localparam logic [2:0] PH_DIM  = 3'd2;
   localparam logic [2:0] PH_IDX  = 3'd3;
   localparam logic [2:0] PH_TC   = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;
   localparam logic [2:0] PH_FAIL = 3'd6;

   logic [srpd_pkg::SPRITE_W-1:0] wanted_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] idx_count_ff, idx_count_in;
   logic [15:0] tc_count_ff, tc_count_in;
   logic [16:0] counter_ff, counter_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pixels_ff, pixels_in;
   logic        zero_pend_ff, zero_pend_in;
   logic [23:0] gather_ff, gather_in;
   logic [1:0]  tc_phase_ff, tc_phase_in;

   logic [7:0] data_byte;
   logic [7:0] palette_index;
   logic [srpd_pkg::COLOR_W-1:0] entry_color;

   logic accept;
   logic out_free;
   logic s1_adv;
   logic chosen;
   logic pal_wr_en;

   logic        emit;
   logic [1:0]  em_kind;
   logic [15:0] em_width;
   logic [15:0] em_height;
   logic [7:0]  em_alpha;
   logic [31:0] em_run;
   logic        em_last;
   logic        em_pal;
   logic [7:0]  em_idx;
   logic [23:0] em_color;

   logic        s1_valid_ff;
   logic [1:0]  s1_kind_ff;
   logic [15:0] s1_width_ff;
   logic [15:0] s1_height_ff;
   logic [7:0]  s1_alpha_ff;
   logic [31:0] s1_run_ff;
   logic        s1_last_ff;
   logic        s1_pal_ff;
   logic        s1_oor_ff;
   logic [23:0] s1_color_ff;

   logic [srpd_pkg::COLOR_W-1:0] ram_rd_data;
   logic [23:0] s1_final_color;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_width_ff;
   logic [15:0] rsp_height_ff;
   logic [23:0] rsp_color_ff;
   logic [7:0]  rsp_alpha_ff;
   logic [31:0] rsp_run_ff;
   logic        rsp_last_ff;

   assign data_byte     = req_tdata[7:0];
   assign palette_index = req_tdata[15:8];
   assign entry_color   = {req_tdata[39:32], req_tdata[31:24], req_tdata[23:16]};

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign chosen = (counter_ff == wanted_ff);

   assign pal_wr_en = accept && (req_tuser == srpd_pkg::CMD_PALETTE) &&
                      ({1'b0, palette_index} < 9'(PALETTE_ENTRIES));

   always_comb begin
      logic [16:0] count_sum;
      logic [15:0] high_full;
      logic [31:0] run;
      logic [31:0] rem;
      logic        do_next;
      logic        do_pixel;
      logic        do_hdr_done;

      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      version_in   = version_ff;
      idx_count_in = idx_count_ff;
      tc_count_in  = tc_count_ff;
      counter_in   = counter_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pixels_in    = pixels_ff;
      zero_pend_in = zero_pend_ff;
      gather_in    = gather_ff;
      tc_phase_in  = tc_phase_ff;

      emit      = 1'b0;
      em_kind   = srpd_pkg::KIND_FAIL;
      em_width  = '0;
      em_height = '0;
      em_alpha  = '0;
      em_run    = '0;
      em_last   = 1'b0;
      em_pal    = 1'b0;
      em_idx    = '0;
      em_color  = '0;

      count_sum   = '0;
      high_full   = '0;
      run         = '0;
      rem         = '0;
      do_next     = 1'b0;
      do_pixel    = 1'b0;
      do_hdr_done = 1'b0;

      case (req_tuser)
         srpd_pkg::CMD_BEGIN: begin
            phase_in     = PH_HEAD;
            hdr_cnt_in   = '0;
            tc_count_in  = '0;
            counter_in   = '0;
            zero_pend_in = 1'b0;
            tc_phase_in  = '0;
         end
         srpd_pkg::CMD_END: begin
            if (phase_ff == PH_IDX && chosen) begin
               emit    = 1'b1;
               em_kind = srpd_pkg::KIND_RUN;
               em_pal  = 1'b1;
               em_run  = pixels_ff;
               em_last = 1'b1;
               pixels_in = '0;
            end else if (phase_ff == PH_HEAD || phase_ff == PH_DIM ||
                         phase_ff == PH_IDX || phase_ff == PH_TC) begin
               emit = 1'b1;
            end
            zero_pend_in = 1'b0;
            phase_in     = PH_IDLE;
         end
         srpd_pkg::CMD_BYTE: begin
            case (phase_ff)
               PH_HEAD: begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
                  case (hdr_cnt_ff)
                     3'd0: begin
                        if (data_byte != srpd_pkg::MAGIC_S) begin
                           emit     = 1'b1;
                           phase_in = PH_FAIL;
                        end
                     end
                     3'd1: begin
                        if (data_byte != srpd_pkg::MAGIC_P) begin
                           emit     = 1'b1;
                           phase_in = PH_FAIL;
                        end
                     end
                     3'd2: version_in = {8'h00, data_byte};
                     3'd3: version_in = {data_byte, version_ff[7:0]};
                     3'd4: idx_count_in = {8'h00, data_byte};
                     3'd5: begin
                        idx_count_in = {data_byte, idx_count_ff[7:0]};
                        if (version_ff < srpd_pkg::MIN_TC_VERSION) begin
                           do_hdr_done = 1'b1;
                           count_sum = {1'b0, idx_count_in} + {1'b0, tc_count_ff};
                        end
                     end
                     3'd6: tc_count_in = {8'h00, data_byte};
                     default: begin
                        tc_count_in = {data_byte, tc_count_ff[7:0]};
                        do_hdr_done = 1'b1;
                        count_sum = {1'b0, idx_count_ff} + {1'b0, tc_count_in};
                     end
                  endcase
                  if (do_hdr_done) begin
                     if (wanted_ff >= count_sum) begin
                        emit     = 1'b1;
                        phase_in = PH_FAIL;
                     end else begin
                        phase_in   = PH_DIM;
                        hdr_cnt_in = '0;
                        counter_in = '0;
                     end
                  end
               end
               PH_DIM: begin
                  hdr_cnt_in = hdr_cnt_ff + 3'd1;
                  case (hdr_cnt_ff)
                     3'd0: width_in = {8'h00, data_byte};
                     3'd1: width_in = {data_byte, width_ff[7:0]};
                     3'd2: height_in = {8'h00, data_byte};
                     default: begin
                        high_full = {data_byte, height_ff[7:0]};
                        height_in = high_full;
                        pixels_in = {16'h0000, width_ff} * {16'h0000, high_full};
                        if (chosen) begin
                           emit      = 1'b1;
                           em_kind   = srpd_pkg::KIND_HEADER;
                           em_width  = width_ff;
                           em_height = high_full;
                           em_last   = (width_ff == '0) || (high_full == '0);
                        end
                        if (width_ff == '0 || high_full == '0) begin
                           do_next = 1'b1;
                        end else begin
                           phase_in = (counter_ff < {1'b0, idx_count_ff}) ? PH_IDX : PH_TC;
                           zero_pend_in = 1'b0;
                           tc_phase_in  = '0;
                        end
                     end
                  endcase
               end
               PH_IDX: begin
                  if (zero_pend_ff) begin
                     zero_pend_in = 1'b0;
                     do_pixel     = 1'b1;
                     em_idx       = '0;
                     if (data_byte == '0) begin
                        run = 32'd1;
                     end else if ({24'h000000, data_byte} < pixels_ff) begin
                        run = {24'h000000, data_byte};
                     end else begin
                        run = pixels_ff;
                     end
                  end else if (data_byte == '0) begin
                     zero_pend_in = 1'b1;
                  end else begin
                     do_pixel = 1'b1;
                     em_idx   = data_byte;
                     run      = 32'd1;
                  end
                  if (do_pixel) begin
                     rem       = pixels_ff - run;
                     pixels_in = rem;
                     if (chosen) begin
                        emit     = 1'b1;
                        em_kind  = srpd_pkg::KIND_RUN;
                        em_pal   = 1'b1;
                        em_alpha = (em_idx == '0) ? 8'h00 : srpd_pkg::ALPHA_OPAQUE;
                        em_run   = run;
                        em_last  = (rem == '0);
                     end
                     do_next = (rem == '0);
                  end
               end
               PH_TC: begin
                  if (tc_phase_ff != 2'd3) begin
                     case (tc_phase_ff)
                        2'd0:    gather_in[7:0]   = data_byte;
                        2'd1:    gather_in[15:8]  = data_byte;
                        default: gather_in[23:16] = data_byte;
                     endcase
                     tc_phase_in = tc_phase_ff + 2'd1;
                  end else begin
                     rem       = pixels_ff - 32'd1;
                     pixels_in = rem;
                     if (chosen) begin
                        emit     = 1'b1;
                        em_kind  = srpd_pkg::KIND_RUN;
                        em_color = gather_ff;
                        em_alpha = data_byte;
                        em_run   = 32'd1;
                        em_last  = (rem == '0);
                     end
                     tc_phase_in = '0;
                     do_next     = (rem == '0);
                  end
               end
               default: begin
               end
            endcase
            if (do_next) begin
               if (chosen) begin
                  phase_in = PH_DONE;
               end else begin
                  counter_in = counter_ff + 17'd1;
                  phase_in   = PH_DIM;
                  hdr_cnt_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff    <= '0;
         phase_ff     <= PH_IDLE;
         hdr_cnt_ff   <= '0;
         zero_pend_ff <= 1'b0;
         tc_phase_ff  <= '0;
         tc_count_ff  <= '0;
         counter_ff   <= '0;
      end else begin
         if (csr_valid) begin
            wanted_ff <= csr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            zero_pend_ff <= zero_pend_in;
            tc_phase_ff  <= tc_phase_in;
            tc_count_ff  <= tc_count_in;
            counter_ff   <= counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         version_ff   <= version_in;
         idx_count_ff <= idx_count_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pixels_ff    <= pixels_in;
         gather_ff    <= gather_in;
      end
   end

   srpd_ram #(
      .WIDTH (srpd_pkg::COLOR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (palette_index[PAL_AW-1:0]),
      .wr_data (entry_color),
      .rd_en   (accept),
      .rd_addr (em_idx[PAL_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= emit;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= em_kind;
         s1_width_ff  <= em_width;
         s1_height_ff <= em_height;
         s1_alpha_ff  <= em_alpha;
         s1_run_ff    <= em_run;
         s1_last_ff   <= em_last;
         s1_pal_ff    <= em_pal;
         s1_oor_ff    <= ({1'b0, em_idx} >= 9'(PALETTE_ENTRIES));
         s1_color_ff  <= em_color;
      end
   end

   always_comb begin
      if (!s1_pal_ff) begin
         s1_final_color = s1_color_ff;
      end else if (s1_oor_ff) begin
         s1_final_color = '0;
      end else begin
         s1_final_color = ram_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_kind_ff   <= s1_kind_ff;
         rsp_width_ff  <= s1_width_ff;
         rsp_height_ff <= s1_height_ff;
         rsp_color_ff  <= s1_final_color;
         rsp_alpha_ff  <= s1_alpha_ff;
         rsp_run_ff    <= s1_run_ff;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_run_ff, rsp_alpha_ff, rsp_color_ff[7:0], rsp_color_ff[15:8],
                        rsp_color_ff[23:16], rsp_height_ff, rsp_width_ff};

endmodule

[hw/rtl/srpd_checker.sv]
// ----------------------------------------------------------------------------
// srpd_checker
// Port-level checks on the sprite decoder result channel.
// ----------------------------------------------------------------------------
module srpd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [1:0]                       rsp_tuser,
   input logic                             rsp_tlast,
   input logic [srpd_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                     $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("Stalled result transaction changed.");

   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == srpd_pkg::KIND_FAIL |-> !rsp_tlast && rsp_tdata == '0)
      else $error("Failed transaction carries data.");

   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == srpd_pkg::KIND_HEADER |->
         rsp_tdata[95:32] == '0 &&
         rsp_tlast == (rsp_tdata[15:0] == '0 || rsp_tdata[31:16] == '0))
      else $error("Header transaction malformed.");

   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == srpd_pkg::KIND_RUN |->
         rsp_tdata[95:64] != '0 && rsp_tdata[31:0] == '0)
      else $error("Pixel run transaction malformed.");

endmodule

bind sprite_rle_palette_decoder srpd_checker u_srpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

[test/sprite_rle_palette_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_rle_palette_decoder_tb
// Self-checking testbench for the sprite decoder. A built-in decoder model
// predicts every header, pixel run and failure from the accepted request
// transactions and compares them field by field with the response stream.
// Directed files cover the format errors, index and true-colour runs, early ends and
// a long response stall; random files, most with random gaps on both sides, follow.
// ----------------------------------------------------------------------------
module sprite_rle_palette_decoder_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HEAD, PH_DIM, PH_IDX, PH_TC, PH_DONE, PH_FAIL
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [31:0] run_length;
      logic        last;
   } sprite_item_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [1:0]                       req_tuser  = srpd_pkg::CMD_PALETTE;
   logic [srpd_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [1:0]                       rsp_tuser;
   logic                             rsp_tlast;
   logic [srpd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [srpd_pkg::SPRITE_W-1:0]    csr_data   = '0;

   sprite_rle_palette_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sprite_item_type decoded_q[$];
   logic [7:0]      file_q[$];
   int              mismatches = 0;
   int              items_sent = 0;
   int              cycles     = 0;
   int              rsp_hold   = 0;
   bit              quiet      = 1'b0;

   // Decoder model state.
   logic [16:0]     want_idx;
   parse_phase_type phase;
   logic [2:0]      hdr_cnt;
   logic [15:0]     version;
   logic [15:0]     n_indexed;
   logic [15:0]     n_truecolor;
   logic [16:0]     img_no;
   logic [15:0]     img_w;
   logic [15:0]     img_h;
   logic [31:0]     px_left;
   logic            zero_pend;
   logic [23:0]     tc_gather;
   logic [1:0]      tc_phase;
   logic [23:0]     palette [0:255];

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("sprite_rle_palette_decoder_tb: errors");
         $finish;
      end
   end

   function automatic void restart_parser();
      phase       = PH_HEAD;
      hdr_cnt     = '0;
      version     = '0;
      n_indexed   = '0;
      n_truecolor = '0;
      img_no      = '0;
      img_w       = '0;
      img_h       = '0;
      px_left     = '0;
      zero_pend   = 1'b0;
      tc_gather   = '0;
      tc_phase    = '0;
   endfunction

   function automatic void emit_item(logic [1:0] kind, logic [15:0] w, logic [15:0] h,
                                     logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic [31:0] run, logic last);
      sprite_item_type it;
      it.kind       = kind;
      it.width      = w;
      it.height     = h;
      it.red        = r;
      it.green      = g;
      it.blue       = b;
      it.alpha      = a;
      it.run_length = run;
      it.last       = last;
      decoded_q.push_back(it);
   endfunction

   function automatic void fail_file();
      phase = PH_FAIL;
      emit_item(srpd_pkg::KIND_FAIL, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0);
   endfunction

   function automatic void emit_indexed(logic [7:0] idx, logic [31:0] run, logic last);
      logic [23:0] c;
      c = palette[idx];
      emit_item(srpd_pkg::KIND_RUN, 16'd0, 16'd0, c[23:16], c[15:8], c[7:0],
                (idx == 8'd0) ? 8'd0 : srpd_pkg::ALPHA_OPAQUE, run, last);
   endfunction

   function automatic logic is_wanted();
      return img_no == want_idx;
   endfunction

   function automatic void advance_image();
      if (is_wanted()) begin
         phase = PH_DONE;
      end else begin
         img_no  = img_no + 17'd1;
         phase   = PH_DIM;
         hdr_cnt = '0;
      end
   endfunction

   function automatic void finish_header();
      if (int'(want_idx) >= int'(n_indexed) + int'(n_truecolor)) begin
         fail_file();
      end else begin
         phase   = PH_DIM;
         hdr_cnt = '0;
         img_no  = '0;
      end
   endfunction

   function automatic void decode_file_byte(logic [7:0] b);
      logic [2:0]  n;
      logic [7:0]  idx;
      logic [31:0] run;
      logic        have_run;
      n        = hdr_cnt;
      have_run = 1'b0;
      idx      = 8'd0;
      run      = 32'd0;
      case (phase)
         PH_HEAD: begin
            hdr_cnt = n + 3'd1;
            case (n)
               3'd0: if (b != srpd_pkg::MAGIC_S) fail_file();
               3'd1: if (b != srpd_pkg::MAGIC_P) fail_file();
               3'd2: version = {8'd0, b};
               3'd3: version[15:8] = b;
               3'd4: n_indexed = {8'd0, b};
               3'd5: begin
                  n_indexed[15:8] = b;
                  if (version < srpd_pkg::MIN_TC_VERSION) finish_header();
               end
               3'd6: n_truecolor = {8'd0, b};
               default: begin
                  n_truecolor[15:8] = b;
                  finish_header();
               end
            endcase
         end
         PH_DIM: begin
            hdr_cnt = n + 3'd1;
            case (n)
               3'd0: img_w = {8'd0, b};
               3'd1: img_w[15:8] = b;
               3'd2: img_h = {8'd0, b};
               default: begin
                  img_h[15:8] = b;
                  px_left = {16'd0, img_w} * {16'd0, img_h};
                  if (is_wanted())
                     emit_item(srpd_pkg::KIND_HEADER, img_w, img_h, 8'd0, 8'd0, 8'd0, 8'd0,
                               32'd0, px_left == 32'd0);
                  if (px_left == 32'd0) begin
                     advance_image();
                  end else begin
                     phase     = (img_no < {1'b0, n_indexed}) ? PH_IDX : PH_TC;
                     zero_pend = 1'b0;
                     tc_phase  = '0;
                     tc_gather = '0;
                  end
               end
            endcase
         end
         PH_IDX: begin
            if (zero_pend) begin
               zero_pend = 1'b0;
               have_run  = 1'b1;
               run = (b == 8'd0) ? 32'd1 : (({24'd0, b} < px_left) ? {24'd0, b} : px_left);
            end else if (b == 8'd0) begin
               zero_pend = 1'b1;
            end else begin
               have_run = 1'b1;
               idx      = b;
               run      = 32'd1;
            end
            if (have_run) begin
               px_left = px_left - run;
               if (is_wanted()) emit_indexed(idx, run, px_left == 32'd0);
               if (px_left == 32'd0) advance_image();
            end
         end
         PH_TC: begin
            if (tc_phase < 2'd3) begin
               tc_gather[8*tc_phase +: 8] = b;
               tc_phase = tc_phase + 2'd1;
            end else begin
               px_left = px_left - 32'd1;
               if (is_wanted())
                  emit_item(srpd_pkg::KIND_RUN, 16'd0, 16'd0, tc_gather[23:16],
                            tc_gather[15:8], tc_gather[7:0], b, 32'd1, px_left == 32'd0);
               tc_phase  = '0;
               tc_gather = '0;
               if (px_left == 32'd0) advance_image();
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void decode_request(logic [1:0] cmd, logic [7:0] b, logic [7:0] pi,
                                          logic [7:0] bl, logic [7:0] gr, logic [7:0] rd);
      case (cmd)
         srpd_pkg::CMD_PALETTE: palette[pi] = {rd, gr, bl};
         srpd_pkg::CMD_BEGIN:   restart_parser();
         srpd_pkg::CMD_BYTE:    decode_file_byte(b);
         default: begin
            if (phase == PH_IDX && is_wanted()) begin
               emit_indexed(8'd0, px_left, 1'b1);
               px_left = 32'd0;
            end else if (phase == PH_HEAD || phase == PH_DIM || phase == PH_IDX ||
                         phase == PH_TC) begin
               fail_file();
            end
            zero_pend = 1'b0;
            phase     = PH_IDLE;
         end
      endcase
   endfunction

   function automatic int draw_gap();
      if (quiet) return 0;
      return $urandom_range(0, 5);
   endfunction

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
      mismatches++;
   endtask

   task automatic check_result();
      sprite_item_type got;
      sprite_item_type want;
      got.kind       = rsp_tuser;
      got.width      = rsp_tdata[15:0];
      got.height     = rsp_tdata[31:16];
      got.red        = rsp_tdata[39:32];
      got.green      = rsp_tdata[47:40];
      got.blue       = rsp_tdata[55:48];
      got.alpha      = rsp_tdata[63:56];
      got.run_length = rsp_tdata[95:64];
      got.last       = rsp_tlast;
      if (decoded_q.size() == 0) begin
         note_mismatch("unexpected transaction kind", 32'(got.kind), 32'd0);
      end else begin
         want = decoded_q.pop_front();
         if (got.kind !== want.kind)
            note_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.width !== want.width)
            note_mismatch("width", 32'(got.width), 32'(want.width));
         if (got.height !== want.height)
            note_mismatch("height", 32'(got.height), 32'(want.height));
         if (got.red !== want.red)
            note_mismatch("red", 32'(got.red), 32'(want.red));
         if (got.green !== want.green)
            note_mismatch("green", 32'(got.green), 32'(want.green));
         if (got.blue !== want.blue)
            note_mismatch("blue", 32'(got.blue), 32'(want.blue));
         if (got.alpha !== want.alpha)
            note_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
         if (got.run_length !== want.run_length)
            note_mismatch("run_length", got.run_length, want.run_length);
         if (got.last !== want.last)
            note_mismatch("last", 32'(got.last), 32'(want.last));
      end
   endtask

   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            check_result();
            idle_left = draw_gap();
         end
         if (rsp_hold > 0) begin
            idle_left = rsp_hold;
            rsp_hold  = 0;
         end
         if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_req(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] pi,
                           input logic [7:0] bl, input logic [7:0] gr, input logic [7:0] rd);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {rd, gr, bl, pi, b};
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_request(cmd, b, pi, bl, gr, rd);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_req(srpd_pkg::CMD_BYTE, b, 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
   endtask

   task automatic send_cmd(input logic [1:0] cmd);
      send_req(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_wanted(input logic [16:0] v);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      want_idx = v;
   endtask

   task automatic add16(input logic [15:0] v);
      file_q.push_back(v[7:0]);
      file_q.push_back(v[15:8]);
   endtask

   task automatic add_head(input logic [15:0] ver, input logic [15:0] ni,
                           input logic [15:0] nt);
      file_q.push_back(srpd_pkg::MAGIC_S);
      file_q.push_back(srpd_pkg::MAGIC_P);
      add16(ver);
      add16(ni);
      if (ver >= srpd_pkg::MIN_TC_VERSION) add16(nt);
   endtask

   task automatic add_index_pixels(input int count);
      int left;
      int choice;
      int n;
      left = count;
      while (left > 0) begin
         choice = $urandom_range(0, 9);
         if (choice < 5) begin
            file_q.push_back(8'($urandom_range(1, 255)));
            left--;
         end else if (choice < 7) begin
            file_q.push_back(8'd0);
            file_q.push_back(8'd0);
            left--;
         end else begin
            n = (choice == 9) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            file_q.push_back(8'd0);
            file_q.push_back(8'(n));
            left = (n < left) ? left - n : 0;
         end
      end
   endtask

   task automatic build_random_file();
      logic [15:0] ver;
      int ni;
      int nt;
      int images;
      int w;
      int h;
      int i;
      file_q.delete();
      case ($urandom_range(0, 5))
         0:       ver = 16'h0100;
         1, 2:    ver = srpd_pkg::MIN_TC_VERSION;
         3:       ver = 16'hFFFF;
         4:       ver = 16'h0200;
         default: ver = 16'($urandom);
      endcase
      ni = $urandom_range(0, 3);
      nt = $urandom_range(0, 3);
      add_head(ver, 16'(ni), 16'(nt));
      images = ni + ((ver >= srpd_pkg::MIN_TC_VERSION) ? nt : 0);
      for (i = 0; i < images; i++) begin
         w = $urandom_range(0, 5);
         h = $urandom_range(0, 4);
         if ($urandom_range(0, 15) == 0) begin
            w = $urandom_range(6, 60);
            h = 1;
         end
         add16(16'(w));
         add16(16'(h));
         if (i < ni) begin
            add_index_pixels(w * h);
         end else begin
            repeat (4 * w * h) file_q.push_back(8'($urandom));
         end
      end
   endtask

   task automatic play_file(input int upto, input bit with_end);
      int k;
      send_cmd(srpd_pkg::CMD_BEGIN);
      for (k = 0; k < upto && k < file_q.size(); k++) begin
         if ($urandom_range(0, 31) == 0)
            send_req(srpd_pkg::CMD_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
         send_byte(file_q[k]);
      end
      if (with_end) send_cmd(srpd_pkg::CMD_END);
   endtask

   task automatic test_palette_fill();
      int i;
      for (i = 0; i < 256; i++) begin
         if (i == 0)
            send_req(srpd_pkg::CMD_PALETTE, 8'($urandom), 8'd0, 8'hFF, 8'hFF, 8'hFF);
         else if (i == 1)
            send_req(srpd_pkg::CMD_PALETTE, 8'($urandom), 8'd1, 8'hAA, 8'h55, 8'hAA);
         else if (i == 255)
            send_req(srpd_pkg::CMD_PALETTE, 8'($urandom), 8'd255, 8'h00, 8'h00, 8'h00);
         else
            send_req(srpd_pkg::CMD_PALETTE, 8'($urandom), 8'(i), 8'($urandom),
                     8'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_format_errors();
      program_wanted(17'd0);
      send_byte(srpd_pkg::MAGIC_S);
      send_cmd(srpd_pkg::CMD_END);
      file_q.delete();
      file_q.push_back(8'h58);
      file_q.push_back(srpd_pkg::MAGIC_P);
      play_file(file_q.size(), 1'b1);
      file_q.delete();
      file_q.push_back(srpd_pkg::MAGIC_S);
      file_q.push_back(8'h51);
      play_file(file_q.size(), 1'b1);
      file_q.delete();
      add_head(srpd_pkg::MIN_TC_VERSION, 16'd0, 16'd0);
      play_file(2, 1'b1);
      play_file(4, 1'b0);
      play_file(file_q.size(), 1'b1);
      file_q.delete();
      add_head(16'h0000, 16'd0, 16'd0);
      play_file(file_q.size(), 1'b1);
   endtask

   task automatic test_indexed_runs();
      program_wanted(17'd1);
      file_q.delete();
      add_head(16'h0100, 16'd2, 16'd0);
      add16(16'd2);
      add16(16'd2);
      file_q.push_back(8'h07);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      file_q.push_back(8'h05);
      add16(16'd3);
      add16(16'd2);
      file_q.push_back(8'hFF);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      file_q.push_back(8'hFF);
      file_q.push_back(8'h01);
      file_q.push_back(8'h02);
      play_file(file_q.size(), 1'b1);
      program_wanted(17'd0);
      file_q.delete();
      add_head(16'h0100, 16'd1, 16'd0);
      add16(16'd0);
      add16(16'd7);
      file_q.push_back(8'h03);
      play_file(file_q.size(), 1'b1);
   endtask

   task automatic test_truecolor();
      program_wanted(17'd2);
      file_q.delete();
      add_head(srpd_pkg::MIN_TC_VERSION, 16'd1, 16'd2);
      add16(16'd1);
      add16(16'd1);
      file_q.push_back(8'h00);
      file_q.push_back(8'h01);
      add16(16'd1);
      add16(16'd1);
      add16(16'h2211);
      add16(16'h4433);
      add16(16'd2);
      add16(16'd1);
      add16(16'h0000);
      add16(16'h0000);
      add16(16'hFFFF);
      add16(16'hFFFF);
      play_file(file_q.size(), 1'b1);
   endtask

   task automatic test_early_end();
      program_wanted(17'd0);
      file_q.delete();
      add_head(16'h0100, 16'd1, 16'd0);
      add16(16'hFFFF);
      add16(16'hFFFF);
      file_q.push_back(8'h05);
      file_q.push_back(8'h00);
      file_q.push_back(8'hFF);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      file_q.push_back(8'h00);
      play_file(file_q.size(), 1'b1);
      file_q.delete();
      add_head(srpd_pkg::MIN_TC_VERSION, 16'd0, 16'd1);
      add16(16'd2);
      add16(16'd1);
      add16(16'h5AA5);
      add16(16'hC33C);
      add16(16'h0FF0);
      play_file(file_q.size(), 1'b1);
      program_wanted(17'd131069);
      file_q.delete();
      add_head(srpd_pkg::MIN_TC_VERSION, 16'hFFFF, 16'hFFFF);
      add16(16'd0);
      add16(16'd0);
      add16(16'd1);
      add16(16'd1);
      file_q.push_back(8'h09);
      play_file(file_q.size(), 1'b1);
      program_wanted(17'h1FFFF);
      file_q.delete();
      add_head(srpd_pkg::MIN_TC_VERSION, 16'hFFFF, 16'hFFFF);
      play_file(file_q.size(), 1'b1);
   endtask

   task automatic test_output_stall();
      program_wanted(17'd0);
      quiet = 1'b1;
      file_q.delete();
      add_head(16'h0100, 16'd1, 16'd0);
      add16(16'd96);
      add16(16'd1);
      repeat (96) file_q.push_back(8'($urandom_range(1, 255)));
      rsp_hold = 300;
      play_file(file_q.size(), 1'b1);
      quiet = 1'b0;
   endtask

   task automatic test_random_files(input logic [16:0] wanted, input bit no_gaps,
                                    input int quota);
      int start;
      int roll;
      int k;
      program_wanted(wanted);
      quiet = no_gaps;
      start = items_sent;
      while (items_sent - start < quota) begin
         build_random_file();
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            play_file(file_q.size(), 1'b1);
         end else if (roll < 77) begin
            play_file($urandom_range(0, file_q.size()), 1'b1);
         end else if (roll < 85) begin
            k = $urandom_range(0, file_q.size() - 1);
            file_q[k] = 8'($urandom);
            play_file(file_q.size(), 1'b1);
         end else if (roll < 92) begin
            play_file($urandom_range(0, file_q.size()), 1'b0);
            play_file(file_q.size(), 1'b1);
         end else if (roll < 96) begin
            play_file(file_q.size(), 1'b0);
         end else begin
            send_byte(8'($urandom));
            send_cmd(srpd_pkg::CMD_END);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      want_idx = '0;
      restart_parser();
      phase = PH_IDLE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_palette_fill();
      test_format_errors();
      test_indexed_runs();
      test_truecolor();
      test_early_end();
      test_output_stall();
      test_random_files(17'd0, 1'b0, 140);
      test_random_files(17'd1, 1'b0, 140);
      test_random_files(17'd3, 1'b1, 140);
      test_random_files(17'($urandom_range(0, 6)), 1'b0, 140);
      test_random_files(17'h1FFFF, 1'b0, 120);
      test_random_files(17'd2, 1'b1, 140);
      wait_drained();
      if (mismatches == 0) begin
         $display("sprite_rle_palette_decoder_tb: clean");
      end else begin
         $display("sprite_rle_palette_decoder_tb: errors");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/srpd_pkg.sv
hw/rtl/srpd_ram.sv
hw/rtl/sprite_rle_palette_decoder.sv
hw/rtl/srpd_checker.sv
test/sprite_rle_palette_decoder_tb.sv
